### rtl/gqtl_pkg.sv
// ============================================================================
// gqtl_pkg
// Shared types, codes and saturation helper for the glyph quad layout block.
// ============================================================================
package gqtl_pkg;

    localparam int SCALE_FRAC = 24;
    localparam int SAT_W      = 48;
    localparam int ADDR_W     = 4;
    localparam int OP_W       = 13;
    localparam int PROD_W     = 38;
    localparam int NUM_OPS    = 6;

    localparam logic [7:0] SPACE_CODE       = 8'd32;
    localparam logic [9:0] FIXED_ADVANCE_PX = 10'd100;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

    localparam logic signed [SAT_W-1:0] SAT_HI = 48'sd2147483647;
    localparam logic signed [SAT_W-1:0] SAT_LO = -48'sd2147483648;

    // register indexes
    localparam logic [1:0] REG_NDC     = 2'd0;
    localparam logic [1:0] REG_SPACING = 2'd1;
    localparam logic [1:0] REG_HMODE   = 2'd2;
    localparam logic [1:0] REG_VMODE   = 2'd3;

    localparam logic [23:0]       NDC_RESET     = 24'd50332;
    localparam logic signed [8:0] SPACING_RESET = 9'sd0;

    // alignment modes
    localparam logic [1:0] H_LEFT   = 2'd0;
    localparam logic [1:0] H_CENTER = 2'd1;
    localparam logic [1:0] H_RIGHT  = 2'd2;
    localparam logic [1:0] V_TOP    = 2'd0;
    localparam logic [1:0] V_CENTER = 2'd1;
    localparam logic [1:0] V_BOTTOM = 2'd2;

    // multiplier operand select, in conversion order
    localparam logic [2:0] OP_BX      = 3'd0;
    localparam logic [2:0] OP_BX_W    = 3'd1;
    localparam logic [2:0] OP_Y_LOW   = 3'd2;
    localparam logic [2:0] OP_Y_HIGH  = 3'd3;
    localparam logic [2:0] OP_ADVANCE = 3'd4;
    localparam logic [2:0] OP_SPACING = 3'd5;

    typedef struct packed {
        logic [23:0]       ndc_per_pixel;
        logic signed [8:0] spacing_pixels;
        logic [1:0]        horizontal_mode;
        logic [1:0]        vertical_mode;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic [2:0] sel;
        logic       mul;
        logic       conv;
        logic       calc;
        logic       upd;
        logic       widen;
        logic       offs;
        logic       rd;
        logic       out_load;
        logic       emit_next;
        logic       clear;
    } dp_cmd_t;

    typedef struct packed {
        logic last_glyph;
        logic out_free;
        logic emit_last;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = INT32_MAX;
        else if (v < SAT_LO)
            r = INT32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/gqtl_cfg.sv
// ============================================================================
// gqtl_cfg
// APB-style register file: scale, spacing and alignment modes.
// ============================================================================
module gqtl_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gqtl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output gqtl_pkg::cfg_t             cfg
);

    gqtl_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ndc_per_pixel   <= gqtl_pkg::NDC_RESET;
            cfg_reg.spacing_pixels  <= gqtl_pkg::SPACING_RESET;
            cfg_reg.horizontal_mode <= gqtl_pkg::H_LEFT;
            cfg_reg.vertical_mode   <= gqtl_pkg::V_BOTTOM;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                gqtl_pkg::REG_NDC:     cfg_reg.ndc_per_pixel   <= pwdata[23:0];
                gqtl_pkg::REG_SPACING: cfg_reg.spacing_pixels  <= $signed(pwdata[8:0]);
                gqtl_pkg::REG_HMODE:   cfg_reg.horizontal_mode <= pwdata[1:0];
                gqtl_pkg::REG_VMODE:   cfg_reg.vertical_mode   <= pwdata[1:0];
                default:               cfg_reg.ndc_per_pixel   <= cfg_reg.ndc_per_pixel;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gqtl_pkg::REG_NDC:     prdata = {8'd0, cfg_reg.ndc_per_pixel};
            gqtl_pkg::REG_SPACING: prdata = {23'd0, cfg_reg.spacing_pixels};
            gqtl_pkg::REG_HMODE:   prdata = {30'd0, cfg_reg.horizontal_mode};
            gqtl_pkg::REG_VMODE:   prdata = {30'd0, cfg_reg.vertical_mode};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

### rtl/gqtl_ctrl.sv
// ============================================================================
// gqtl_ctrl
// Sequencer: multiply/convert steps per glyph, alignment, quad emission.
// ============================================================================
module gqtl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               glyph_valid,
    output logic               glyph_ready,
    input  gqtl_pkg::dp_stat_t stat,
    output gqtl_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL     = 3'd1;
    localparam logic [2:0] ST_CALC    = 3'd2;
    localparam logic [2:0] ST_UPD     = 3'd3;
    localparam logic [2:0] ST_WIDEN   = 3'd4;
    localparam logic [2:0] ST_OFFS    = 3'd5;
    localparam logic [2:0] ST_EMIT_RD = 3'd6;
    localparam logic [2:0] ST_EMIT_LD = 3'd7;

    localparam logic [2:0] LAST_STEP = 3'(gqtl_pkg::NUM_OPS);

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;

    assign glyph_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.sel    = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load  = glyph_valid;
                step_next = 3'd0;
                if (glyph_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // product of step s is rounded in step s+1
                cmd.mul   = (step_reg != LAST_STEP);
                cmd.conv  = (step_reg != 3'd0);
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = stat.last_glyph ? ST_WIDEN : ST_IDLE;
            end
            ST_WIDEN:
            begin
                cmd.widen  = 1'b1;
                state_next = ST_OFFS;
            end
            ST_OFFS:
            begin
                cmd.offs   = 1'b1;
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/gqtl_datapath.sv
// ============================================================================
// gqtl_datapath
// Shared scale multiplier, coordinate math, bounding box, quad store, output.
// ============================================================================
module gqtl_datapath #(
    parameter int MAX_GLYPHS = 64,
    parameter int FRAC_BITS  = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gqtl_pkg::dp_cmd_t   cmd,
    output gqtl_pkg::dp_stat_t  stat,
    input  gqtl_pkg::cfg_t      cfg,
    input  logic [7:0]          char_code,
    input  logic [9:0]          glyph_width,
    input  logic [9:0]          glyph_height,
    input  logic signed [10:0]  bearing_x,
    input  logic signed [10:0]  bearing_y,
    input  logic signed [10:0]  origin_y,
    input  logic [9:0]          advance_pixels,
    input  logic                last_glyph,
    input  logic                quad_ready,
    output logic                quad_valid,
    output logic signed [31:0]  quad_min_x,
    output logic signed [31:0]  quad_min_y,
    output logic signed [31:0]  quad_max_x,
    output logic signed [31:0]  quad_max_y,
    output logic                last_quad,
    output logic                dropped_glyphs
);

    localparam int SAT_W  = gqtl_pkg::SAT_W;
    localparam int PROD_W = gqtl_pkg::PROD_W;
    localparam int OP_W   = gqtl_pkg::OP_W;
    localparam int UP_SH  = (FRAC_BITS > gqtl_pkg::SCALE_FRAC) ?
                            FRAC_BITS - gqtl_pkg::SCALE_FRAC : 0;
    localparam int DN_SH  = (FRAC_BITS < gqtl_pkg::SCALE_FRAC) ?
                            gqtl_pkg::SCALE_FRAC - FRAC_BITS : 0;
    localparam int CONV_W = PROD_W + UP_SH + 1;
    localparam int IDX_W  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CNT_W  = $clog2(MAX_GLYPHS + 1);
    localparam int OFF_W  = 35;

    localparam logic signed [CONV_W-1:0] RND_K   = CONV_W'((1 << DN_SH) >> 1);
    localparam logic signed [SAT_W-1:0]  ONE     = SAT_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [SAT_W-1:0]  TWO     = SAT_W'(64'sd2 <<< FRAC_BITS);
    localparam logic [CNT_W-1:0]         CNT_MAX = CNT_W'(MAX_GLYPHS);

    // latched glyph fields
    logic [7:0]         code_reg;
    logic [9:0]         w_reg, h_reg, adv_reg;
    logic signed [10:0] bx_reg, by_reg, oy_reg;
    logic               last_reg;

    logic signed [OP_W-1:0]   op_sel;
    logic signed [OP_W-1:0]   w_s, h_s, adv_s;
    logic [9:0]               adv_px;
    logic signed [24:0]       ndc_s;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [CONV_W-1:0] conv_shift, conv_rnd;
    logic signed [31:0]       fix_new;
    logic signed [31:0]       fix_reg [0:gqtl_pkg::NUM_OPS-1];

    logic signed [31:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [31:0] pen_reg;
    logic signed [31:0] box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic signed [31:0] wide;
    logic [CNT_W-1:0]   count_reg;
    logic               overflow_reg;

    logic signed [SAT_W-1:0] size_x, size_y;
    logic signed [OFF_W-1:0] off_x_reg, off_y_reg, off_x_next, off_y_next;

    logic [IDX_W-1:0] k_reg;
    logic [63:0]      quad_low_mem  [0:MAX_GLYPHS-1];
    logic [63:0]      quad_high_mem [0:MAX_GLYPHS-1];
    logic [63:0]      rlow_reg, rhigh_reg;

    logic               quad_valid_reg, last_quad_reg, dropped_reg;
    logic signed [31:0] qx0_reg, qy0_reg, qx1_reg, qy1_reg;

    // ---------------------------------------------------------------- operands
    assign w_s    = OP_W'($signed({1'b0, w_reg}));
    assign h_s    = OP_W'($signed({1'b0, h_reg}));
    assign adv_px = ((code_reg == gqtl_pkg::SPACE_CODE) || (w_reg == 10'd0)) ?
                    gqtl_pkg::FIXED_ADVANCE_PX : adv_reg;
    assign adv_s  = OP_W'($signed({1'b0, adv_px}));
    assign ndc_s  = $signed({1'b0, cfg.ndc_per_pixel});

    always_comb
    begin
        case (cmd.sel)
            gqtl_pkg::OP_BX:      op_sel = OP_W'(bx_reg);
            gqtl_pkg::OP_BX_W:    op_sel = OP_W'(bx_reg) + w_s;
            gqtl_pkg::OP_Y_LOW:   op_sel = OP_W'(by_reg) - h_s + OP_W'(oy_reg);
            gqtl_pkg::OP_Y_HIGH:  op_sel = OP_W'(by_reg) + OP_W'(oy_reg);
            gqtl_pkg::OP_ADVANCE: op_sel = adv_s;
            gqtl_pkg::OP_SPACING: op_sel = OP_W'(cfg.spacing_pixels);
            default:              op_sel = '0;
        endcase
    end

    assign prod_next  = op_sel * ndc_s;
    // round half up, then floor shift, to FRAC_BITS
    assign conv_shift = CONV_W'(prod_reg) <<< UP_SH;
    assign conv_rnd   = (conv_shift + RND_K) >>> DN_SH;
    assign fix_new    = gqtl_pkg::sat32(SAT_W'(conv_rnd));

    assign wide   = gqtl_pkg::sat32(SAT_W'(box_min_x_reg) + SAT_W'(pen_reg));
    assign size_x = SAT_W'(box_max_x_reg) - SAT_W'(box_min_x_reg);
    assign size_y = SAT_W'(box_max_y_reg) - SAT_W'(box_min_y_reg);

    always_comb
    begin
        case (cfg.horizontal_mode)
            gqtl_pkg::H_CENTER: off_x_next = OFF_W'(ONE - (size_x >>> 1));
            gqtl_pkg::H_RIGHT:  off_x_next = OFF_W'(TWO - size_x);
            default:            off_x_next = '0;
        endcase
        case (cfg.vertical_mode)
            gqtl_pkg::V_CENTER: off_y_next = OFF_W'(ONE - (size_y >>> 1));
            gqtl_pkg::V_TOP:    off_y_next = OFF_W'(TWO - size_y);
            default:            off_y_next = '0;
        endcase
    end

    assign stat.last_glyph = last_reg;
    assign stat.out_free   = !quad_valid_reg || quad_ready;
    assign stat.emit_last  = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg <= char_code;
            w_reg    <= glyph_width;
            h_reg    <= glyph_height;
            bx_reg   <= bearing_x;
            by_reg   <= bearing_y;
            oy_reg   <= origin_y;
            adv_reg  <= advance_pixels;
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.conv)
        begin
            for (int i = 0; i < gqtl_pkg::NUM_OPS - 1; i++)
                fix_reg[i] <= fix_reg[i+1];
            fix_reg[gqtl_pkg::NUM_OPS-1] <= fix_new;
        end
        if (cmd.calc)
        begin
            x0_reg <= gqtl_pkg::sat32(SAT_W'(fix_reg[gqtl_pkg::OP_BX]) - ONE
                                      + SAT_W'(pen_reg));
            x1_reg <= gqtl_pkg::sat32(SAT_W'(fix_reg[gqtl_pkg::OP_BX_W]) - ONE
                                      + SAT_W'(pen_reg));
            y0_reg <= gqtl_pkg::sat32(SAT_W'(fix_reg[gqtl_pkg::OP_Y_LOW]) - ONE);
            y1_reg <= gqtl_pkg::sat32(SAT_W'(fix_reg[gqtl_pkg::OP_Y_HIGH]) - ONE);
        end
        if (cmd.offs)
        begin
            off_x_reg <= off_x_next;
            off_y_reg <= off_y_next;
        end
        if (cmd.out_load)
        begin
            qx0_reg <= gqtl_pkg::sat32(SAT_W'($signed(rlow_reg[31:0]))  + SAT_W'(off_x_reg));
            qy0_reg <= gqtl_pkg::sat32(SAT_W'($signed(rlow_reg[63:32])) + SAT_W'(off_y_reg));
            qx1_reg <= gqtl_pkg::sat32(SAT_W'($signed(rhigh_reg[31:0])) + SAT_W'(off_x_reg));
            qy1_reg <= gqtl_pkg::sat32(SAT_W'($signed(rhigh_reg[63:32])) + SAT_W'(off_y_reg));
            last_quad_reg <= stat.emit_last;
            dropped_reg   <= overflow_reg;
        end
    end

    // ---------------------------------------------------------------- quad store
    always_ff @(posedge clk)
    begin
        if (cmd.upd && (count_reg < CNT_MAX))
        begin
            quad_low_mem[count_reg[IDX_W-1:0]]  <= {y0_reg, x0_reg};
            quad_high_mem[count_reg[IDX_W-1:0]] <= {y1_reg, x1_reg};
        end
        if (cmd.rd)
        begin
            rlow_reg  <= quad_low_mem[k_reg];
            rhigh_reg <= quad_high_mem[k_reg];
        end
    end

    // ---------------------------------------------------------------- string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= 1'b0;
            pen_reg        <= '0;
            box_min_x_reg  <= gqtl_pkg::INT32_MAX;
            box_min_y_reg  <= gqtl_pkg::INT32_MAX;
            box_max_x_reg  <= gqtl_pkg::INT32_MIN;
            box_max_y_reg  <= gqtl_pkg::INT32_MIN;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            k_reg          <= '0;
            quad_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                last_reg <= last_glyph;
            if (cmd.upd)
            begin
                if (x0_reg < box_min_x_reg)
                    box_min_x_reg <= x0_reg;
                if (y0_reg < box_min_y_reg)
                    box_min_y_reg <= y0_reg;
                if (x1_reg > box_max_x_reg)
                    box_max_x_reg <= x1_reg;
                if (y1_reg > box_max_y_reg)
                    box_max_y_reg <= y1_reg;
                if (count_reg < CNT_MAX)
                    count_reg <= count_reg + CNT_W'(1);
                else
                    overflow_reg <= 1'b1;
                pen_reg <= gqtl_pkg::sat32(SAT_W'(pen_reg)
                                           + SAT_W'(fix_reg[gqtl_pkg::OP_ADVANCE])
                                           + SAT_W'(fix_reg[gqtl_pkg::OP_SPACING]));
            end
            if (cmd.widen && (wide > box_max_x_reg))
                box_max_x_reg <= wide;
            if (cmd.offs)
                k_reg <= '0;
            else if (cmd.emit_next)
                k_reg <= k_reg + IDX_W'(1);
            if (cmd.out_load)
                quad_valid_reg <= 1'b1;
            else if (quad_ready)
                quad_valid_reg <= 1'b0;
            if (cmd.clear)
            begin
                pen_reg       <= '0;
                box_min_x_reg <= gqtl_pkg::INT32_MAX;
                box_min_y_reg <= gqtl_pkg::INT32_MAX;
                box_max_x_reg <= gqtl_pkg::INT32_MIN;
                box_max_y_reg <= gqtl_pkg::INT32_MIN;
                count_reg     <= '0;
                overflow_reg  <= 1'b0;
            end
        end
    end

    assign quad_valid     = quad_valid_reg;
    assign quad_min_x     = qx0_reg;
    assign quad_min_y     = qy0_reg;
    assign quad_max_x     = qx1_reg;
    assign quad_max_y     = qy1_reg;
    assign last_quad      = last_quad_reg;
    assign dropped_glyphs = dropped_reg;

endmodule

### rtl/glyph_quad_text_layout.sv
// ============================================================================
// glyph_quad_text_layout
// Lays out a string of glyphs as scaled quads, aligns the run, emits quads.
// ============================================================================
// Glyphs: taken one at a time; six products share one 13x25 multiplier, each
//   followed by a rounding step, then a quad step and a pen/box update step.
// Last glyph: then a box-widening step and an offset step, then per stored quad
//   a store read and an offset add, which waits while the quad output is stalled.
// Reset: registers to their defaults, pen/box/count cleared; store contents are
//   undefined until written and are not cleared.
module glyph_quad_text_layout #(
    parameter int MAX_GLYPHS = 64,
    parameter int FRAC_BITS  = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gqtl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        glyph_valid,
    output logic                        glyph_ready,
    input  logic [7:0]                  char_code,
    input  logic [9:0]                  glyph_width,
    input  logic [9:0]                  glyph_height,
    input  logic signed [10:0]          bearing_x,
    input  logic signed [10:0]          bearing_y,
    input  logic signed [10:0]          origin_y,
    input  logic [9:0]                  advance_pixels,
    input  logic                        last_glyph,
    output logic                        quad_valid,
    input  logic                        quad_ready,
    output logic signed [31:0]          quad_min_x,
    output logic signed [31:0]          quad_min_y,
    output logic signed [31:0]          quad_max_x,
    output logic signed [31:0]          quad_max_y,
    output logic                        last_quad,
    output logic                        dropped_glyphs
);

    gqtl_pkg::cfg_t     cfg;
    gqtl_pkg::dp_cmd_t  cmd;
    gqtl_pkg::dp_stat_t stat;

    gqtl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gqtl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph_valid (glyph_valid),
        .glyph_ready (glyph_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    gqtl_datapath #(
        .MAX_GLYPHS (MAX_GLYPHS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg            (cfg),
        .char_code      (char_code),
        .glyph_width    (glyph_width),
        .glyph_height   (glyph_height),
        .bearing_x      (bearing_x),
        .bearing_y      (bearing_y),
        .origin_y       (origin_y),
        .advance_pixels (advance_pixels),
        .last_glyph     (last_glyph),
        .quad_ready     (quad_ready),
        .quad_valid     (quad_valid),
        .quad_min_x     (quad_min_x),
        .quad_min_y     (quad_min_y),
        .quad_max_x     (quad_max_x),
        .quad_max_y     (quad_max_y),
        .last_quad      (last_quad),
        .dropped_glyphs (dropped_glyphs)
    );

endmodule

### rtl/gqtl_checker.sv
// ============================================================================
// gqtl_checker
// Port-level checks of the glyph quad layout block, bound to the top level.
// ============================================================================
module gqtl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               glyph_valid,
    input logic               glyph_ready,
    input logic               quad_valid,
    input logic               quad_ready,
    input logic signed [31:0] quad_min_x,
    input logic signed [31:0] quad_max_y,
    input logic               last_quad,
    input logic               dropped_glyphs
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && !quad_ready |=> quad_valid && $stable(quad_min_x)
                                      && $stable(quad_max_y) && $stable(last_quad))
        else $error("stalled quad beat changed");

    // one glyph at a time: busy right after a glyph beat
    a_glyph_busy: assert property (@(posedge clk) disable iff (!rst_n)
        glyph_valid && glyph_ready |=> !glyph_ready)
        else $error("glyph accepted back to back");

    // no new glyph while a run is still being emitted
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && quad_ready && !last_quad |-> !glyph_ready)
        else $error("glyph input open during quad run");

    // drop flag is constant across one run
    a_drop_stable: assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && quad_ready && !last_quad |=> !quad_valid || $stable(dropped_glyphs))
        else $error("dropped flag changed within a run");

endmodule

bind glyph_quad_text_layout gqtl_checker u_gqtl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .glyph_valid    (glyph_valid),
    .glyph_ready    (glyph_ready),
    .quad_valid     (quad_valid),
    .quad_ready     (quad_ready),
    .quad_min_x     (quad_min_x),
    .quad_max_y     (quad_max_y),
    .last_quad      (last_quad),
    .dropped_glyphs (dropped_glyphs)
);

### sim/glyph_quad_layout_checker.sv
// ============================================================================
// glyph_quad_layout_checker
// Watches the register port and both beat channels of the glyph layout block,
// lays out each accepted glyph on its own copy of the pen, box and quad store,
// and compares every emitted quad beat with the oldest quad still owed.
// ============================================================================
module glyph_quad_layout_checker
    import gqtl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    input  logic                     pready,
    input  logic                     glyph_valid,
    input  logic                     glyph_ready,
    input  logic [7:0]               char_code,
    input  logic [9:0]               glyph_width,
    input  logic [9:0]               glyph_height,
    input  logic signed [10:0]       bearing_x,
    input  logic signed [10:0]       bearing_y,
    input  logic signed [10:0]       origin_y,
    input  logic [9:0]               advance_pixels,
    input  logic                     last_glyph,
    input  logic                     quad_valid,
    input  logic                     quad_ready,
    input  logic signed [31:0]       quad_min_x,
    input  logic signed [31:0]       quad_min_y,
    input  logic signed [31:0]       quad_max_x,
    input  logic signed [31:0]       quad_max_y,
    input  logic                     last_quad,
    input  logic                     dropped_glyphs,
    output int                       failures,
    output int                       quads_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STORE_DEPTH = 64;
    // coordinates carry as many fraction bits as the scale register
    localparam longint ONE         = longint'(1) << SCALE_FRAC;

    typedef struct {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic               last;
        logic               dropped;
    } quad_t;

    quad_t expected_quads[$];

    logic [23:0]       scale;
    logic signed [8:0] spacing;
    logic [1:0]        h_mode;
    logic [1:0]        v_mode;

    longint pen;
    longint box_lo_x, box_lo_y, box_hi_x, box_hi_y;
    longint store_lo_x[STORE_DEPTH];
    longint store_lo_y[STORE_DEPTH];
    longint store_hi_x[STORE_DEPTH];
    longint store_hi_y[STORE_DEPTH];
    int     stored;
    bit     overflow;

    function automatic longint clamp32(input longint v);
        if (v > longint'(INT32_MAX))
            return longint'(INT32_MAX);
        if (v < longint'(INT32_MIN))
            return longint'(INT32_MIN);
        return v;
    endfunction

    // pixel count times scale; exact, since both sides use the same fraction
    function automatic longint to_ndc(input longint pix);
        return clamp32(pix * longint'({1'b0, scale}));
    endfunction

    task automatic clear_string();
        pen      = 0;
        box_lo_x = longint'(INT32_MAX);
        box_lo_y = longint'(INT32_MAX);
        box_hi_x = longint'(INT32_MIN);
        box_hi_y = longint'(INT32_MIN);
        stored   = 0;
        overflow = 0;
    endtask

    task automatic lay_out_glyph();
        longint bx, by, oy, w, h, sp;
        longint x0, x1, y0, y1, adv_px, wide, size_x, size_y, off_x, off_y;
        quad_t  q;
        bx = bearing_x;
        by = bearing_y;
        oy = origin_y;
        w  = glyph_width;
        h  = glyph_height;
        sp = spacing;

        x0 = clamp32(-ONE + to_ndc(bx) + pen);
        x1 = clamp32(-ONE + to_ndc(bx + w) + pen);
        y0 = clamp32(-ONE + to_ndc(by - h + oy));
        y1 = clamp32(-ONE + to_ndc(by + oy));

        if (x0 < box_lo_x) box_lo_x = x0;
        if (y0 < box_lo_y) box_lo_y = y0;
        if (x1 > box_hi_x) box_hi_x = x1;
        if (y1 > box_hi_y) box_hi_y = y1;

        if (stored < STORE_DEPTH) begin
            store_lo_x[stored] = x0;
            store_lo_y[stored] = y0;
            store_hi_x[stored] = x1;
            store_hi_y[stored] = y1;
            stored++;
        end
        else begin
            overflow = 1;
        end

        if (char_code == SPACE_CODE || w == 0)
            adv_px = FIXED_ADVANCE_PX;
        else
            adv_px = advance_pixels;
        pen = clamp32(pen + to_ndc(adv_px) + to_ndc(sp));

        if (!last_glyph)
            return;

        // box must span at least the full pen travel
        wide = clamp32(box_lo_x + pen);
        if (wide > box_hi_x) box_hi_x = wide;
        size_x = box_hi_x - box_lo_x;
        size_y = box_hi_y - box_lo_y;

        case (h_mode)
            H_CENTER: off_x = -(size_x >>> 1) + ONE;
            H_RIGHT:  off_x = -size_x + 2 * ONE;
            default:  off_x = 0;
        endcase
        case (v_mode)
            V_CENTER: off_y = -(size_y >>> 1) + ONE;
            V_TOP:    off_y = -size_y + 2 * ONE;
            default:  off_y = 0;
        endcase

        for (int k = 0; k < stored; k++) begin
            q.min_x   = 32'(clamp32(store_lo_x[k] + off_x));
            q.min_y   = 32'(clamp32(store_lo_y[k] + off_y));
            q.max_x   = 32'(clamp32(store_hi_x[k] + off_x));
            q.max_y   = 32'(clamp32(store_hi_y[k] + off_y));
            q.last    = (k + 1 == stored);
            q.dropped = overflow;
            expected_quads.push_back(q);
        end
        clear_string();
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_quad();
        quad_t q;
        if (expected_quads.size() == 0) begin
            $error("quad beat with nothing owed: min_x %0d min_y %0d", quad_min_x, quad_min_y);
            failures++;
            return;
        end
        q = expected_quads.pop_front();
        check_field("quad_min_x", q.min_x, quad_min_x);
        check_field("quad_min_y", q.min_y, quad_min_y);
        check_field("quad_max_x", q.max_x, quad_max_x);
        check_field("quad_max_y", q.max_y, quad_max_y);
        check_field("last_quad", {63'd0, q.last}, {63'd0, last_quad});
        check_field("dropped_glyphs", {63'd0, q.dropped}, {63'd0, dropped_glyphs});
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scale   = NDC_RESET;
            spacing = SPACING_RESET;
            h_mode  = H_LEFT;
            v_mode  = V_BOTTOM;
            clear_string();
            expected_quads.delete();
            failures      = 0;
            quads_pending = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_NDC:     scale   = pwdata[23:0];
                    REG_SPACING: spacing = pwdata[8:0];
                    REG_HMODE:   h_mode  = pwdata[1:0];
                    REG_VMODE:   v_mode  = pwdata[1:0];
                    default:     ;
                endcase
            end
            if (quad_valid && quad_ready)
                check_quad();
            if (glyph_valid && glyph_ready)
                lay_out_glyph();
            quads_pending = expected_quads.size();
        end
    end

endmodule

### sim/glyph_quad_text_layout_test.sv
// ============================================================================
// glyph_quad_text_layout_test
// Feeds strings of glyphs to the layout block under changing scale, spacing
// and alignment settings, with random gaps and stalls on both beat channels;
// the checker beside the block predicts and compares every quad.
// ============================================================================
module glyph_quad_text_layout_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gqtl_pkg::*;

    localparam int RANDOM_ITEMS  = 330;
    localparam int IDLE_LIMIT    = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int OVERFLOW_LEN  = 70;

    // mode code 3 is unused by the block
    localparam logic [1:0] H_UNUSED = 2'd3;
    localparam logic [1:0] V_UNUSED = 2'd3;

    typedef struct {
        logic [7:0]        code;
        logic [9:0]        w;
        logic [9:0]        h;
        logic signed [10:0] bx;
        logic signed [10:0] by;
        logic signed [10:0] oy;
        logic [9:0]        adv;
        logic              last;
    } glyph_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     glyph_valid;
    logic                     glyph_ready;
    logic [7:0]               char_code;
    logic [9:0]               glyph_width;
    logic [9:0]               glyph_height;
    logic signed [10:0]       bearing_x;
    logic signed [10:0]       bearing_y;
    logic signed [10:0]       origin_y;
    logic [9:0]               advance_pixels;
    logic                     last_glyph;
    logic                     quad_valid;
    logic                     quad_ready;
    logic signed [31:0]       quad_min_x;
    logic signed [31:0]       quad_min_y;
    logic signed [31:0]       quad_max_x;
    logic signed [31:0]       quad_max_y;
    logic                     last_quad;
    logic                     dropped_glyphs;

    int failures;
    int quads_pending;
    int items_sent;
    int idle_cycles;
    bit send_calm;
    bit hold_ask;
    bit hold_taken;

    glyph_quad_text_layout dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .glyph_valid    (glyph_valid),
        .glyph_ready    (glyph_ready),
        .char_code      (char_code),
        .glyph_width    (glyph_width),
        .glyph_height   (glyph_height),
        .bearing_x      (bearing_x),
        .bearing_y      (bearing_y),
        .origin_y       (origin_y),
        .advance_pixels (advance_pixels),
        .last_glyph     (last_glyph),
        .quad_valid     (quad_valid),
        .quad_ready     (quad_ready),
        .quad_min_x     (quad_min_x),
        .quad_min_y     (quad_min_y),
        .quad_max_x     (quad_max_x),
        .quad_max_y     (quad_max_y),
        .last_quad      (last_quad),
        .dropped_glyphs (dropped_glyphs)
    );

    glyph_quad_layout_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .glyph_valid    (glyph_valid),
        .glyph_ready    (glyph_ready),
        .char_code      (char_code),
        .glyph_width    (glyph_width),
        .glyph_height   (glyph_height),
        .bearing_x      (bearing_x),
        .bearing_y      (bearing_y),
        .origin_y       (origin_y),
        .advance_pixels (advance_pixels),
        .last_glyph     (last_glyph),
        .quad_valid     (quad_valid),
        .quad_ready     (quad_ready),
        .quad_min_x     (quad_min_x),
        .quad_min_y     (quad_min_y),
        .quad_max_x     (quad_max_x),
        .quad_max_y     (quad_max_y),
        .last_quad      (last_quad),
        .dropped_glyphs (dropped_glyphs),
        .failures       (failures),
        .quads_pending  (quads_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // stall/gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_length(input int string_idx);
        int r;
        if (string_idx == 1)
            return OVERFLOW_LEN;
        if (string_idx == 3)
            return $urandom_range(4, 10);
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 6);
        if (r < 92)
            return $urandom_range(7, 24);
        return $urandom_range(40, 66);
    endfunction

    function automatic glyph_t make_glyph(input int code, input int w, input int h,
                                          input int bx, input int by, input int oy,
                                          input int adv, input bit last);
        glyph_t g;
        g.code = 8'(code);
        g.w    = 10'(w);
        g.h    = 10'(h);
        g.bx   = 11'(bx);
        g.by   = 11'(by);
        g.oy   = 11'(oy);
        g.adv  = 10'(adv);
        g.last = last;
        return g;
    endfunction

    function automatic glyph_t rand_glyph(input bit last);
        glyph_t g;
        g.code = ($urandom_range(0, 7) == 0) ? SPACE_CODE : 8'($urandom);
        g.w    = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom);
        g.h    = 10'($urandom);
        g.bx   = 11'($urandom);
        g.by   = 11'($urandom);
        g.oy   = 11'($urandom);
        g.adv  = 10'($urandom);
        g.last = last;
        return g;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_glyph(input glyph_t g);
        int gap;
        glyph_valid    <= 1'b1;
        char_code      <= g.code;
        glyph_width    <= g.w;
        glyph_height   <= g.h;
        bearing_x      <= g.bx;
        bearing_y      <= g.by;
        origin_y       <= g.oy;
        advance_pixels <= g.adv;
        last_glyph     <= g.last;
        do @(posedge clk); while (!glyph_ready);
        items_sent++;
        gap = (send_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            glyph_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every owed quad has come out and the block has gone quiet
    task automatic settle();
        glyph_valid <= 1'b0;
        do @(posedge clk); while (quads_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic randomize_settings();
        int                r;
        logic [23:0]       ndc;
        logic signed [8:0] sp;
        r = $urandom_range(0, 99);
        if (r < 25)
            ndc = 24'hFFFFFF;
        else if (r < 35)
            ndc = 24'd0;
        else if (r < 75)
            ndc = 24'($urandom_range(20000, 200000));
        else
            ndc = 24'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            sp = -9'sd256;
        else if (r == 1)
            sp = 9'sd255;
        else
            sp = 9'($urandom);
        write_reg(REG_NDC, {8'd0, ndc});
        write_reg(REG_SPACING, {23'd0, sp});
        write_reg(REG_HMODE, {30'd0, 2'($urandom_range(0, 3))});
        write_reg(REG_VMODE, {30'd0, 2'($urandom_range(0, 3))});
    endtask

    task automatic send_string(input int len);
        for (int i = 0; i < len; i++)
            send_glyph(rand_glyph(i == len - 1));
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off
    initial begin
        int gap_left;
        bit calm;
        gap_left   = 0;
        calm       = 0;
        hold_taken = 0;
        quad_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_ask && !hold_taken && quad_valid) begin
                hold_taken = 1;
                gap_left   = LONG_HOLD;
            end
            if ($urandom_range(0, 299) == 0)
                calm = !calm;
            if (gap_left > 0) begin
                quad_ready <= 1'b0;
                gap_left--;
            end
            else begin
                quad_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (glyph_valid && glyph_ready) || (quad_valid && quad_ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int n_directed;
        int strings;
        int r;
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        glyph_valid    <= 1'b0;
        char_code      <= '0;
        glyph_width    <= '0;
        glyph_height   <= '0;
        bearing_x      <= '0;
        bearing_y      <= '0;
        origin_y       <= '0;
        advance_pixels <= '0;
        last_glyph     <= 1'b0;
        idle_cycles    <= 0;
        items_sent = 0;
        send_calm  = 0;
        hold_ask   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default scale, left/bottom; blank glyph alone, extremes, space, zero width
        write_reg(REG_NDC, {8'd0, NDC_RESET});
        write_reg(REG_SPACING, 32'd0);
        write_reg(REG_HMODE, {30'd0, H_LEFT});
        write_reg(REG_VMODE, {30'd0, V_BOTTOM});
        send_glyph(make_glyph(0, 0, 0, 0, 0, 0, 0, 1));
        send_glyph(make_glyph(255, 1023, 1023, 1023, 1023, 1023, 1023, 0));
        send_glyph(make_glyph(0, 1, 0, -1024, -1024, -1024, 0, 0));
        send_glyph(make_glyph(SPACE_CODE, 5, 20, 3, -4, 2, 7, 0));
        send_glyph(make_glyph(65, 0, 9, 1, 2, 3, 40, 1));
        settle();

        // most negative spacing, centered both ways
        write_reg(REG_SPACING, 32'h100);
        write_reg(REG_HMODE, {30'd0, H_CENTER});
        write_reg(REG_VMODE, {30'd0, V_CENTER});
        send_glyph(make_glyph(72, 300, 500, -200, 100, -50, 600, 0));
        send_glyph(make_glyph(SPACE_CODE, 0, 0, 0, 0, 0, 1023, 0));
        send_glyph(make_glyph(105, 12, 900, 1023, -1024, 1023, 3, 1));
        settle();

        // full-scale: the pen and the large coordinates saturate; right/top
        write_reg(REG_NDC, 32'h00FF_FFFF);
        write_reg(REG_SPACING, 32'h0FF);
        write_reg(REG_HMODE, {30'd0, H_RIGHT});
        write_reg(REG_VMODE, {30'd0, V_TOP});
        send_glyph(make_glyph(255, 1023, 0, 1023, 1023, 1023, 1023, 0));
        send_glyph(make_glyph(1, 1023, 1023, -1024, -1024, -1024, 1023, 0));
        send_glyph(make_glyph(128, 512, 256, 0, 0, 0, 1023, 1));
        settle();

        // zero scale, unused mode codes on both axes
        write_reg(REG_NDC, 32'd0);
        write_reg(REG_HMODE, {30'd0, H_UNUSED});
        write_reg(REG_VMODE, {30'd0, V_UNUSED});
        send_glyph(make_glyph(66, 700, 300, -5, 9, 11, 80, 0));
        send_glyph(make_glyph(SPACE_CODE, 1023, 1023, 1023, 1023, 1023, 0, 1));
        settle();

        n_directed = items_sent;
        randomize_settings();
        strings = 0;
        while (items_sent < n_directed + RANDOM_ITEMS) begin
            send_calm = ($urandom_range(0, 4) == 0);
            if (strings == 3)
                hold_ask = 1;
            send_string(pick_length(strings));
            // strings 3 and 4 go back to back into the receiver's long hold-off
            if (strings != 3) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    settle();
                    randomize_settings();
                end
                else if (r < 40)
                    settle();
            end
            strings++;
        end
        settle();

        if (failures == 0 && quads_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
